// ===== rtl/fccd_pkg.sv =====
// ============================================================================
// fccd_pkg: shared types and microcode for the four channel cell drain unit
// Word layouts of both channels, channel and operation codes, control word
// format and the read-only microprogram of the sequencer.
// ============================================================================
package fccd_pkg;

    // Channel codes, also the order in which a tick drains the stores
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_ALPHA = 2'd3;
    localparam int         NUM_CHAN   = 4;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Input word
    typedef struct packed {
        logic        operation;
        logic [7:0]  red_amount;
        logic [7:0]  green_amount;
        logic [7:0]  blue_amount;
        logic [15:0] alpha_amount;
        logic [1:0]  read_channel;
        logic [7:0]  read_index;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0]  head_position;
        logic [7:0]  red_shortfall;
        logic [7:0]  green_shortfall;
        logic [7:0]  blue_shortfall;
        logic [15:0] alpha_shortfall;
        logic [7:0]  cell_level;
    } t_out_word;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        STEP_CLEAR    = 4'd0,
        STEP_WAIT     = 4'd1,
        STEP_DISPATCH = 4'd2,
        STEP_CH_START = 4'd3,
        STEP_CELL_RD  = 4'd4,
        STEP_CELL_EV  = 4'd5,
        STEP_CH_END   = 4'd6,
        STEP_FINISH   = 4'd7,
        STEP_RD_ISSUE = 4'd8,
        STEP_RD_CAPT  = 4'd9
    } t_step;

    // Datapath operations
    typedef enum logic [3:0] {
        U_NOP,
        U_CLEAR,
        U_LOAD,
        U_CH_INIT,
        U_ISSUE,
        U_EVAL,
        U_CH_DONE,
        U_EMIT,
        U_RD_ISSUE,
        U_RD_CAPT
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_READ_OP,
        C_REST_ZERO,
        C_MORE,
        C_MORE_CH,
        C_CLR_LAST,
        C_OUT_FREE
    } t_cond;

    // Control word: on a true condition jump to target, else hold or advance
    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_step target;
        logic  hold;
    } t_ctrl_word;

    // Microprogram ROM
    function automatic t_ctrl_word ctrl_rom(t_step step);
        t_ctrl_word w;
        unique case (step)
            STEP_CLEAR:    w = '{U_CLEAR,    C_CLR_LAST,  STEP_WAIT,     1'b1};
            STEP_WAIT:     w = '{U_LOAD,     C_ACCEPT,    STEP_DISPATCH, 1'b1};
            STEP_DISPATCH: w = '{U_NOP,      C_READ_OP,   STEP_RD_ISSUE, 1'b0};
            STEP_CH_START: w = '{U_CH_INIT,  C_REST_ZERO, STEP_CH_END,   1'b0};
            STEP_CELL_RD:  w = '{U_ISSUE,    C_ALWAYS,    STEP_CELL_EV,  1'b0};
            STEP_CELL_EV:  w = '{U_EVAL,     C_MORE,      STEP_CELL_RD,  1'b0};
            STEP_CH_END:   w = '{U_CH_DONE,  C_MORE_CH,   STEP_CH_START, 1'b0};
            STEP_FINISH:   w = '{U_EMIT,     C_OUT_FREE,  STEP_WAIT,     1'b1};
            STEP_RD_ISSUE: w = '{U_RD_ISSUE, C_ALWAYS,    STEP_RD_CAPT,  1'b0};
            STEP_RD_CAPT:  w = '{U_RD_CAPT,  C_ALWAYS,    STEP_FINISH,   1'b0};
            default:       w = '{U_NOP,      C_ALWAYS,    STEP_WAIT,     1'b0};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/four_channel_cell_drain_unit.sv =====
// Tick: after acceptance a dispatch step, then per channel a start step, a store
//   read and an update per visited cell and an end step; then the result is emitted.
// Read: dispatch, store read issue, capture, then emit. One word at a time; the
//   block is ready again once the result is in the output register, even as it waits.
// Reset (synchronous, active low) starts a fill pass over every cell address that
//   sets every cell to INITIAL_LEVEL; o_ready stays low until it ends.
// ============================================================================
// four_channel_cell_drain_unit: four byte-cell stores drained by a shared head
// A microcoded sequencer walks the red, green, blue and alpha stores a cell at
// a time and reports the head and undrained amounts, or reads a cell.
// ============================================================================
module four_channel_cell_drain_unit #(
    parameter int CELL_COUNT    = 256,
    parameter int INITIAL_LEVEL = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fccd_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output fccd_pkg::t_out_word o_data
);

    localparam int              AW        = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int              SW        = $clog2(CELL_COUNT + 1);
    localparam logic [AW-1:0]   LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [SW-1:0]   SWEEP_LEN = SW'(CELL_COUNT);
    localparam logic [7:0]      INIT_BYTE = 8'(INITIAL_LEVEL);

    // Sequencer
    fccd_pkg::t_step      r_upc;
    fccd_pkg::t_step      n_upc;
    fccd_pkg::t_ctrl_word ctrl;
    logic                 cond_hit;

    // Handshake
    logic in_accept;
    logic out_free;

    // Datapath registers
    fccd_pkg::t_in_word  r_in;
    fccd_pkg::t_out_word r_res;
    fccd_pkg::t_out_word r_out;
    logic                r_out_valid;
    logic [1:0]          r_ch;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_clr_addr;
    logic [15:0]         r_rest;
    logic [SW-1:0]       r_swept;

    // Store ports
    logic [AW-1:0]              mem_addr;
    logic [fccd_pkg::NUM_CHAN-1:0] mem_we;
    logic [7:0]                 mem_wdata;
    logic [7:0]                 r_rdata [fccd_pkg::NUM_CHAN];

    // Cell step results
    logic [7:0]    cell_rd;
    logic [15:0]   ch_amount;
    logic [AW-1:0] pos_next;
    logic [AW-1:0] e_pos;
    logic [15:0]   e_rest;
    logic [SW-1:0] e_swept;
    logic [7:0]    e_level;
    logic          e_more;
    logic          read_in_range;
    fccd_pkg::t_out_word emit_word;

    assign ctrl      = fccd_pkg::ctrl_rom(r_upc);
    assign o_ready   = (r_upc == fccd_pkg::STEP_WAIT);
    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    assign cell_rd       = r_rdata[r_ch];
    assign pos_next      = (r_pos == LAST_CELL) ? '0 : r_pos + AW'(1);
    assign read_in_range = int'(r_in.read_index) < CELL_COUNT;

    // Select the amount of the current channel
    always_comb begin
        unique case (r_ch)
            fccd_pkg::CHAN_RED:   ch_amount = 16'(r_in.red_amount);
            fccd_pkg::CHAN_GREEN: ch_amount = 16'(r_in.green_amount);
            fccd_pkg::CHAN_BLUE:  ch_amount = 16'(r_in.blue_amount);
            default:              ch_amount = r_in.alpha_amount;
        endcase
    end

    // Evaluate one cell: skip, partly drain, or empty it
    always_comb begin
        e_pos   = r_pos;
        e_rest  = r_rest;
        e_swept = r_swept;
        e_level = cell_rd;
        if (cell_rd == 8'd0) begin
            e_pos   = pos_next;
            e_swept = r_swept + SW'(1);
        end else if (16'(cell_rd) >= r_rest) begin
            e_level = cell_rd - r_rest[7:0];
            e_rest  = '0;
            if (e_level == 8'd0) begin
                e_pos = pos_next;
            end
        end else begin
            e_level = 8'd0;
            e_rest  = r_rest - 16'(cell_rd);
            e_pos   = pos_next;
            e_swept = r_swept + SW'(1);
        end
        e_more = (e_rest != 16'd0) && (e_swept < SWEEP_LEN);
    end

    // Stamp the head onto the finished result
    always_comb begin
        emit_word               = r_res;
        emit_word.head_position = 8'(r_head);
    end

    // Resolve the jump condition and the next step
    always_comb begin
        unique case (ctrl.cond)
            fccd_pkg::C_ALWAYS:    cond_hit = 1'b1;
            fccd_pkg::C_ACCEPT:    cond_hit = in_accept;
            fccd_pkg::C_READ_OP:   cond_hit = (r_in.operation == fccd_pkg::OP_READ);
            fccd_pkg::C_REST_ZERO: cond_hit = (ch_amount == 16'd0);
            fccd_pkg::C_MORE:      cond_hit = e_more;
            fccd_pkg::C_MORE_CH:   cond_hit = (r_ch != fccd_pkg::CHAN_ALPHA);
            fccd_pkg::C_CLR_LAST:  cond_hit = (r_clr_addr == LAST_CELL);
            fccd_pkg::C_OUT_FREE:  cond_hit = out_free;
            default:               cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            n_upc = ctrl.target;
        end else if (ctrl.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = fccd_pkg::t_step'(4'(r_upc) + 4'd1);
        end
    end

    // Drive the store ports
    always_comb begin
        mem_addr  = r_pos;
        mem_we    = '0;
        mem_wdata = e_level;
        unique case (ctrl.uop)
            fccd_pkg::U_CLEAR: begin
                mem_addr  = r_clr_addr;
                mem_we    = '1;
                mem_wdata = INIT_BYTE;
            end
            fccd_pkg::U_EVAL: begin
                mem_we[r_ch] = 1'b1;
            end
            fccd_pkg::U_RD_ISSUE: begin
                mem_addr = AW'(r_in.read_index);
            end
            default: begin
            end
        endcase
    end

    // One store per channel, registered read
    for (genvar g = 0; g < fccd_pkg::NUM_CHAN; g++) begin : g_lane
        logic [7:0] r_store [CELL_COUNT];

        always_ff @(posedge i_clk) begin
            if (mem_we[g]) begin
                r_store[mem_addr] <= mem_wdata;
            end
            r_rdata[g] <= r_store[mem_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= fccd_pkg::STEP_CLEAR;
            r_clr_addr  <= '0;
            r_ch        <= fccd_pkg::CHAN_RED;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (ctrl.uop == fccd_pkg::U_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (ctrl.uop == fccd_pkg::U_LOAD && in_accept) begin
                r_ch <= fccd_pkg::CHAN_RED;
            end
            if (ctrl.uop == fccd_pkg::U_CH_DONE) begin
                r_head <= r_pos;
                r_ch   <= r_ch + 2'd1;
            end
            if (ctrl.uop == fccd_pkg::U_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (ctrl.uop)
            fccd_pkg::U_LOAD: begin
                if (in_accept) begin
                    r_in  <= i_data;
                    r_res <= '0;
                end
            end
            fccd_pkg::U_CH_INIT: begin
                r_pos   <= r_head;
                r_swept <= '0;
                r_rest  <= ch_amount;
            end
            fccd_pkg::U_EVAL: begin
                r_pos   <= e_pos;
                r_rest  <= e_rest;
                r_swept <= e_swept;
            end
            fccd_pkg::U_CH_DONE: begin
                unique case (r_ch)
                    fccd_pkg::CHAN_RED:   r_res.red_shortfall   <= r_rest[7:0];
                    fccd_pkg::CHAN_GREEN: r_res.green_shortfall <= r_rest[7:0];
                    fccd_pkg::CHAN_BLUE:  r_res.blue_shortfall  <= r_rest[7:0];
                    default:              r_res.alpha_shortfall <= r_rest;
                endcase
            end
            fccd_pkg::U_RD_CAPT: begin
                r_res.cell_level <= read_in_range ? r_rdata[r_in.read_channel] : 8'd0;
            end
            fccd_pkg::U_EMIT: begin
                if (out_free) begin
                    r_out <= emit_word;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/fccd_checker.sv =====
// ============================================================================
// fccd_checker: port-level checks for the four channel cell drain unit
// Watches both handshakes and the result word; attached by bind.
// ============================================================================
module fccd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input fccd_pkg::t_in_word  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input fccd_pkg::t_out_word o_data
);

    // Hold off input while the stores fill after reset
    a_fill_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_ready)
        else $error("input ready right after reset");

    // Take one word at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while busy");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // A tick result carries no cell level
    a_tick_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.red_shortfall != 8'd0 || o_data.green_shortfall != 8'd0 ||
                     o_data.blue_shortfall != 8'd0 || o_data.alpha_shortfall != 16'd0))
        |-> (o_data.cell_level == 8'd0))
        else $error("shortfall and cell level both set");

    // A read into an empty output slot answers after its dispatch, issue and capture steps
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.operation == fccd_pkg::OP_READ && !o_valid)
        |-> ##5 o_valid)
        else $error("read result late");

endmodule

bind four_channel_cell_drain_unit fccd_checker u_fccd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for four_channel_cell_drain_unit
// Drives drain ticks and cell reads through the valid/ready input channel and
// checks every output word against a behavioral model of the four cell
// stores and the shared head. The sender works in bursts and the receiver
// stalls in windows. The run ends by emptying every store and sweeping it.
// ============================================================================
module tb_top;

    localparam int CELLS         = 256;
    localparam int FILL_LEVEL    = 255;
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_WORDS  = 500;
    localparam int EXHAUST_TICKS = 330;

    // Receiver stall modes
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOKE
    } t_rx_mode;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    fccd_pkg::t_in_word  i_data  = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    fccd_pkg::t_out_word o_data;

    // Model of the stores and the shared head
    logic [7:0] cell_lvl [fccd_pkg::NUM_CHAN][CELLS];
    logic [7:0] drain_pos;

    fccd_pkg::t_out_word pending_results[$];
    fccd_pkg::t_out_word oldest_result;
    int        error_count = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    int        rx_window   = 0;
    t_rx_mode  rx_mode     = RX_OPEN;

    four_channel_cell_drain_unit #(
        .CELL_COUNT    (CELLS),
        .INITIAL_LEVEL (FILL_LEVEL)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Walk one store from the shared head; return the undrained rest
    function automatic int unsigned walk_store(int ch, int unsigned amount);
        int unsigned rest;
        int unsigned p;
        int unsigned swept;
        int unsigned lvl;
        rest  = amount;
        p     = drain_pos;
        swept = 0;
        if (rest == 0)
            return 0;
        while (rest > 0 && swept < CELLS) begin
            lvl = cell_lvl[ch][p];
            if (lvl == 0) begin
                p = (p + 1) % CELLS;
                swept++;
            end else if (lvl >= rest) begin
                cell_lvl[ch][p] = 8'(lvl - rest);
                if (cell_lvl[ch][p] == 8'd0)
                    p = (p + 1) % CELLS;
                rest = 0;
            end else begin
                rest -= lvl;
                cell_lvl[ch][p] = 8'd0;
                p = (p + 1) % CELLS;
                swept++;
            end
        end
        drain_pos = 8'(p);
        return rest;
    endfunction

    // Apply one word to the model and return the word the block must emit
    function automatic fccd_pkg::t_out_word drain_or_read(fccd_pkg::t_in_word w);
        fccd_pkg::t_out_word r;
        r = '0;
        if (w.operation == fccd_pkg::OP_TICK) begin
            r.red_shortfall   = 8'(walk_store(fccd_pkg::CHAN_RED, w.red_amount));
            r.green_shortfall = 8'(walk_store(fccd_pkg::CHAN_GREEN, w.green_amount));
            r.blue_shortfall  = 8'(walk_store(fccd_pkg::CHAN_BLUE, w.blue_amount));
            r.alpha_shortfall = 16'(walk_store(fccd_pkg::CHAN_ALPHA, w.alpha_amount));
        end else begin
            r.cell_level = cell_lvl[w.read_channel][w.read_index];
        end
        r.head_position = drain_pos;
        return r;
    endfunction

    // Build a tick; the read fields carry noise
    function automatic fccd_pkg::t_in_word make_tick(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b, logic [15:0] a);
        fccd_pkg::t_in_word w;
        w.operation    = fccd_pkg::OP_TICK;
        w.red_amount   = r;
        w.green_amount = g;
        w.blue_amount  = b;
        w.alpha_amount = a;
        w.read_channel = 2'($urandom);
        w.read_index   = 8'($urandom);
        return w;
    endfunction

    // Build a read; the amount fields carry noise
    function automatic fccd_pkg::t_in_word make_read(logic [1:0] ch, logic [7:0] idx);
        fccd_pkg::t_in_word w;
        w.operation    = fccd_pkg::OP_READ;
        w.red_amount   = 8'($urandom);
        w.green_amount = 8'($urandom);
        w.blue_amount  = 8'($urandom);
        w.alpha_amount = 16'($urandom);
        w.read_channel = ch;
        w.read_index   = idx;
        return w;
    endfunction

    // Mostly small amounts so the stores drain slowly
    function automatic logic [7:0] rgb_amount();
        case ($urandom_range(0, 7)) inside
            0:       return 8'd0;
            [1:4]:   return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one word; when a burst runs out, start a new one, often after a gap
    task automatic send_word(input fccd_pkg::t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_data  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(drain_or_read(w));
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // The first and the last cell of every store
    task automatic test_fresh_reads();
        for (int ch = 0; ch < fccd_pkg::NUM_CHAN; ch++) begin
            send_word(make_read(2'(ch), 8'd0));
            send_word(make_read(2'(ch), 8'd255));
        end
    endtask

    // Zero amounts leave the head and all cells alone
    task automatic test_zero_tick();
        send_word(make_tick(8'd0, 8'd0, 8'd0, 16'd0));
        send_word(make_read(fccd_pkg::CHAN_RED, 8'd0));
    endtask

    // Exact amounts empty a cell and move the head on
    task automatic test_exact_empty();
        send_word(make_tick(8'd255, 8'd255, 8'd255, 16'd0));
        send_word(make_read(fccd_pkg::CHAN_RED, 8'd0));
        send_word(make_read(fccd_pkg::CHAN_GREEN, 8'd1));
        send_word(make_read(fccd_pkg::CHAN_BLUE, 8'd2));
        wait_for_results();
    endtask

    // Partial drains hold the head; alpha spills into the next cell
    task automatic test_partial_drain();
        send_word(make_tick(8'd1, 8'd254, 8'd0, 16'd300));
        send_word(make_read(fccd_pkg::CHAN_RED, 8'd3));
        send_word(make_read(fccd_pkg::CHAN_GREEN, 8'd3));
        send_word(make_read(fccd_pkg::CHAN_ALPHA, 8'd3));
        send_word(make_read(fccd_pkg::CHAN_ALPHA, 8'd4));
        send_word(make_tick(8'd254, 8'd1, 8'd128, 16'd210));
        send_word(make_read(fccd_pkg::CHAN_RED, 8'd4));
    endtask

    // Random ticks and reads, with reads aimed near the head half the time
    task automatic test_random_mix();
        logic [7:0]  idx;
        logic [15:0] alpha;
        repeat (RANDOM_WORDS) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1)
                    idx = 8'($urandom);
                else
                    idx = drain_pos + 8'($urandom_range(0, 4)) - 8'd2;
                send_word(make_read(2'($urandom), idx));
            end else begin
                case ($urandom_range(0, 7))
                    0:       alpha = 16'd0;
                    1:       alpha = 16'($urandom_range(0, 511));
                    default: alpha = 16'($urandom_range(0, 63));
                endcase
                send_word(make_tick(rgb_amount(), rgb_amount(), rgb_amount(), alpha));
            end
            if ($urandom_range(0, 149) == 0)
                wait_for_results();
        end
    endtask

    // Drain every store dry, then sweep the empty stores
    task automatic test_exhaust_stores();
        repeat (EXHAUST_TICKS) begin
            send_word(make_tick(8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                                8'($urandom_range(200, 255)), 16'($urandom)));
            if ($urandom_range(0, 7) == 0)
                send_word(make_read(2'($urandom), 8'($urandom)));
        end
        send_word(make_tick(8'd255, 8'd255, 8'd255, 16'hFFFF));
        repeat (6) begin
            send_word(make_tick(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)));
            send_word(make_read(2'($urandom), 8'($urandom)));
        end
    endtask

    // Main sequence
    initial begin
        for (int ch = 0; ch < fccd_pkg::NUM_CHAN; ch++)
            for (int i = 0; i < CELLS; i++)
                cell_lvl[ch][i] = 8'(FILL_LEVEL);
        drain_pos = 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_reads();
        test_zero_tick();
        test_exact_empty();
        test_partial_drain();
        test_random_mix();
        test_exhaust_stores();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Receiver: change stall mode every window
    always @(posedge i_clk) begin
        if (rx_window == 0) begin
            rx_window <= $urandom_range(16, 96);
            rx_mode   <= t_rx_mode'($urandom_range(0, 2));
        end else begin
            rx_window <= rx_window - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_RANDOM: i_ready <= 1'($urandom_range(0, 1));
            default:   i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each output word with the oldest pending result
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("output word with nothing pending: %p", o_data);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("head_position", oldest_result.head_position, o_data.head_position);
                check_field("red_shortfall", oldest_result.red_shortfall, o_data.red_shortfall);
                check_field("green_shortfall", oldest_result.green_shortfall,
                            o_data.green_shortfall);
                check_field("blue_shortfall", oldest_result.blue_shortfall,
                            o_data.blue_shortfall);
                check_field("alpha_shortfall", oldest_result.alpha_shortfall,
                            o_data.alpha_shortfall);
                check_field("cell_level", oldest_result.cell_level, o_data.cell_level);
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/fccd_pkg.sv
rtl/four_channel_cell_drain_unit.sv
rtl/fccd_checker.sv
verif/tb_top.sv
